[rtl/core/multiplexed_control_scanner_deadband_unit_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the multiplexed control scanner deadband unit
// ---------------------------------------------------------------------------
`ifndef MULTIPLEXED_CONTROL_SCANNER_DEADBAND_UNIT_DEFINES_SVH
`define MULTIPLEXED_CONTROL_SCANNER_DEADBAND_UNIT_DEFINES_SVH

// Same-cycle implication, switched off while rst is high.
`define MCSD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, switched off while rst is high.
`define MCSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/mcsd_pkg.sv]
// ---------------------------------------------------------------------------
// mcsd_pkg
// Types and constants shared by the scanner deadband unit.
// ---------------------------------------------------------------------------
package mcsd_pkg;

   localparam int NUM_CHANNELS_DEF = 6;
   localparam int MASK_W           = 6;
   localparam int VAL_W            = 10;
   localparam int PTR_W            = 3;
   localparam int RD_W             = 16;
   localparam int ADDR_W           = 4;
   localparam int DATA_W           = 32;

   localparam logic [RD_W-1:0]  RD_OUT_OF_RANGE = 16'hFFFF;
   localparam logic [VAL_W-1:0] DEADBAND_RST    = 10'd4;

   localparam logic [1:0] ACT_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_CLEAR  = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   localparam logic [1:0] REG_ANALOG_MASK  = 2'd0;
   localparam logic [1:0] REG_DIGITAL_MASK = 2'd1;
   localparam logic [1:0] REG_DEADBAND     = 2'd2;

   typedef struct packed {
      logic [1:0]       action;
      logic [VAL_W-1:0] adc_value;
      logic             pin_level;
      logic [2:0]       read_index;
   } req_type;

   typedef struct packed {
      logic [RD_W-1:0]   read_value;
      logic [MASK_W-1:0] changed_flags;
      logic [PTR_W-1:0]  next_channel;
   } rsp_type;

   typedef struct packed {
      logic [MASK_W-1:0] analog_mask;
      logic [MASK_W-1:0] digital_mask;
      logic [VAL_W-1:0]  deadband;
   } cfg_type;

endpackage

[rtl/core/multiplexed_control_scanner_deadband_unit.sv]
// ---------------------------------------------------------------------------
// multiplexed_control_scanner_deadband_unit
// Round-robin channel scanner with analog deadband and changed flags.
// ---------------------------------------------------------------------------
// Results are registered in the result buffer. One request per cycle while
// req_ready is high; the channel ring updates in one pass.
// A two-entry result buffer keeps req_ready high while one result waits.
// Reset (synchronous, active high) clears channel values, flags, pointer and
// masks, sets the deadband to 4 and empties the result buffer.
module multiplexed_control_scanner_deadband_unit #(
   parameter int NUM_CHANNELS = mcsd_pkg::NUM_CHANNELS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  mcsd_pkg::req_type            req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output mcsd_pkg::rsp_type            rsp_data,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mcsd_pkg::ADDR_W-1:0] paddr,
   input  logic [mcsd_pkg::DATA_W-1:0] pwdata,
   output logic [mcsd_pkg::DATA_W-1:0] prdata,
   output logic                         pready
);
   import mcsd_pkg::*;

   cfg_type cfg;
   rsp_type step_rsp;
   logic    can_push;
   logic    push;

   assign req_ready = can_push;
   assign push      = req_valid & can_push;

   mcsd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mcsd_scan #(.NUM_CHANNELS(NUM_CHANNELS)) u_scan (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .push  (push),
      .req   (req_data),
      .rsp   (step_rsp)
   );

   mcsd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (step_rsp),
      .can_push  (can_push),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[rtl/core/mcsd_csr.sv]
// ---------------------------------------------------------------------------
// mcsd_csr
// Configuration registers behind the APB-style port.
// ---------------------------------------------------------------------------
module mcsd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [mcsd_pkg::ADDR_W-1:0] paddr,
   input  logic [mcsd_pkg::DATA_W-1:0] pwdata,
   output logic [mcsd_pkg::DATA_W-1:0] prdata,
   output logic                         pready,
   output mcsd_pkg::cfg_type            cfg
);
   import mcsd_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_ANALOG_MASK:  cfg_in.analog_mask  = pwdata[MASK_W-1:0];
            REG_DIGITAL_MASK: cfg_in.digital_mask = pwdata[MASK_W-1:0];
            REG_DEADBAND:     cfg_in.deadband     = pwdata[VAL_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.analog_mask  <= '0;
         cfg_ff.digital_mask <= '0;
         cfg_ff.deadband     <= DEADBAND_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_ANALOG_MASK:  prdata = {{(DATA_W-MASK_W){1'b0}}, cfg_ff.analog_mask};
         REG_DIGITAL_MASK: prdata = {{(DATA_W-MASK_W){1'b0}}, cfg_ff.digital_mask};
         REG_DEADBAND:     prdata = {{(DATA_W-VAL_W){1'b0}}, cfg_ff.deadband};
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/mcsd_scan.sv]
// ---------------------------------------------------------------------------
// mcsd_scan
// Channel value ring, changed flags and scan pointer, updated once per beat.
// ---------------------------------------------------------------------------
module mcsd_scan #(
   parameter int NUM_CHANNELS = mcsd_pkg::NUM_CHANNELS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  mcsd_pkg::cfg_type cfg,
   input  logic              push,
   input  mcsd_pkg::req_type req,
   output mcsd_pkg::rsp_type rsp
);
   import mcsd_pkg::*;

   localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic [PTR_W:0] NUM_CH = (PTR_W+1)'(NUM_CHANNELS);

   // The ring is kept rotated so that entry 0 always holds the channel under
   // the scan pointer; entry k holds channel (pointer + k) modulo the count.
   logic [VAL_W-1:0]  ring_ff [NUM_CHANNELS];
   logic [VAL_W-1:0]  ring_in [NUM_CHANNELS];
   logic [MASK_W-1:0] flags_ff;
   logic [MASK_W-1:0] flags_in;
   logic [PTR_W-1:0]  ptr_ff;
   logic [PTR_W-1:0]  ptr_in;

   logic [7:0]        analog8;
   logic [7:0]        digital8;
   logic              is_analog;
   logic              is_digital;
   logic [VAL_W-1:0]  cur_val;
   logic [VAL_W-1:0]  diff;
   logic [VAL_W-1:0]  store_val;
   logic              store_en;
   logic              changed;
   logic [VAL_W-1:0]  new_val;
   logic [PTR_W:0]    ptr_inc;
   logic [PTR_W:0]    rd_off;
   logic              sample;

   assign sample     = push && (req.action == ACT_SAMPLE);
   assign analog8    = {{(8-MASK_W){1'b0}}, cfg.analog_mask};
   assign digital8   = {{(8-MASK_W){1'b0}}, cfg.digital_mask};
   assign is_analog  = analog8[ptr_ff];
   assign is_digital = digital8[ptr_ff];
   assign cur_val    = ring_ff[0];
   assign diff       = (cur_val > req.adc_value) ? (cur_val - req.adc_value)
                                                 : (req.adc_value - cur_val);
   assign store_val  = is_analog ? req.adc_value : {{(VAL_W-1){1'b0}}, req.pin_level};
   assign store_en   = is_analog ? (diff > cfg.deadband) : is_digital;
   assign changed    = store_en && (store_val != cur_val);
   assign new_val    = store_en ? store_val : cur_val;
   assign ptr_inc    = {1'b0, ptr_ff} + (PTR_W+1)'(1);

   always_comb begin
      flags_in = flags_ff;
      ptr_in   = ptr_ff;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
         ring_in[k] = ring_ff[k];
      end
      if (push) begin
         case (req.action)
            ACT_SAMPLE: begin
               for (int k = 0; k < NUM_CHANNELS - 1; k++) begin
                  ring_in[k] = ring_ff[k+1];
               end
               ring_in[NUM_CHANNELS-1] = new_val;
               if (changed) begin
                  flags_in = flags_ff | (MASK_W'(1) << ptr_ff);
               end
               ptr_in = (ptr_inc >= NUM_CH) ? '0 : ptr_inc[PTR_W-1:0];
            end
            ACT_CLEAR: flags_in = '0;
            default:   flags_in = flags_ff;
         endcase
      end
   end

   // Position of the requested channel in the ring after this beat.
   always_comb begin
      rd_off = {1'b0, req.read_index} + NUM_CH - {1'b0, ptr_in};
      if (rd_off >= NUM_CH) begin
         rd_off = rd_off - NUM_CH;
      end
   end

   always_comb begin
      rsp.changed_flags = flags_in;
      rsp.next_channel  = ptr_in;
      if ({1'b0, req.read_index} >= NUM_CH) begin
         rsp.read_value = RD_OUT_OF_RANGE;
      end else begin
         rsp.read_value = {{(RD_W-VAL_W){1'b0}}, ring_in[rd_off[IDX_W-1:0]]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            ring_ff[k] <= '0;
         end
         flags_ff <= '0;
         ptr_ff   <= '0;
      end else if (sample) begin
         for (int k = 0; k < NUM_CHANNELS; k++) begin
            ring_ff[k] <= ring_in[k];
         end
         flags_ff <= flags_in;
         ptr_ff   <= ptr_in;
      end else begin
         flags_ff <= flags_in;
      end
   end

endmodule

[rtl/core/mcsd_out_buf.sv]
// ---------------------------------------------------------------------------
// mcsd_out_buf
// Result register with a skid stage, so a beat is taken while a result waits.
// ---------------------------------------------------------------------------
module mcsd_out_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mcsd_pkg::rsp_type push_data,
   output logic              can_push,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mcsd_pkg::rsp_type rsp_data
);
   import mcsd_pkg::*;

   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;
   logic    pop;

   assign pop      = out_valid_ff & rsp_ready;
   assign can_push = ~skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = push;
            skid_data_in  = push_data;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[rtl/core/mcsd_checker.sv]
// ---------------------------------------------------------------------------
// mcsd_checker
// Port-level checks for the scanner deadband unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "multiplexed_control_scanner_deadband_unit_defines.svh"

module mcsd_checker #(
   parameter int NUM_CHANNELS = mcsd_pkg::NUM_CHANNELS_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input mcsd_pkg::rsp_type            rsp_data
);
   import mcsd_pkg::*;

   localparam logic [PTR_W:0] NUM_CH = (PTR_W+1)'(NUM_CHANNELS);

   logic ptr_ok;
   logic value_ok;
   logic rsp_stall;

   assign ptr_ok    = {1'b0, rsp_data.next_channel} < NUM_CH;
   assign value_ok  = (rsp_data.read_value == RD_OUT_OF_RANGE) ||
                      (rsp_data.read_value[RD_W-1:VAL_W] == '0);
   assign rsp_stall = rsp_valid && !rsp_ready;

   // A held result keeps its payload until it is taken.
   `MCSD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data))
   // The scan pointer never leaves the channel range.
   `MCSD_ASSERT_IMPLY(a_ptr_range, clock, reset, rsp_valid, ptr_ok)
   // Stored values are converter-wide unless the index was out of range.
   `MCSD_ASSERT_IMPLY(a_value_width, clock, reset, rsp_valid, value_ok)
   // Coming out of reset the buffer is empty and accepts a beat.
   `MCSD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready)

endmodule

bind multiplexed_control_scanner_deadband_unit mcsd_checker #(
   .NUM_CHANNELS(NUM_CHANNELS)
) u_mcsd_checker (.*);

[verif/multiplexed_control_scanner_deadband_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the multiplexed control scanner deadband unit
// Drives request beats through a short directed table and then several
// randomised configuration phases. Every accepted beat is run through a
// behavioural copy of the scanner, and each result beat is compared field by
// field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module multiplexed_control_scanner_deadband_unit_tb;
   import mcsd_pkg::*;

   localparam int NCH             = NUM_CHANNELS_DEF;
   localparam int NUM_PHASES      = 6;
   localparam int ITEMS_PER_PHASE = 140;
   localparam int HOLD_CYCLES     = 200;
   localparam int CYCLE_LIMIT     = 200000;

   // No register lives at this index, so a write there must be ignored.
   localparam logic [1:0] REG_UNUSED  = 2'd3;
   // The fourth action code is not defined and behaves as a query.
   localparam logic [1:0] ACT_UNKNOWN = 2'd3;

   typedef struct packed {
      logic              is_write;
      logic [1:0]        reg_sel;
      logic [DATA_W-1:0] wdata;
      req_type           item;
      logic              typed;
      rsp_type           golden;
   } plan_row_type;

   logic                clock     = 1'b0;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                psel      = 1'b0;
   logic                penable   = 1'b0;
   logic                pwrite    = 1'b0;
   logic [ADDR_W-1:0]   paddr     = '0;
   logic [DATA_W-1:0]   pwdata    = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   // Shadow state of the scanner.
   cfg_type             shadow_cfg;
   logic [VAL_W-1:0]    chan_level [NCH];
   logic [MASK_W-1:0]   changed_q;
   logic [PTR_W-1:0]    scan_q;

   rsp_type             expected_scans [$];
   plan_row_type        plan [$];
   int                  mismatches   = 0;
   int                  cycle_count  = 0;
   bit                  idle_on      = 1'b1;
   bit                  hold_off_req = 1'b0;

   multiplexed_control_scanner_deadband_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic void cfg_apply(input logic [1:0] reg_sel, input logic [DATA_W-1:0] value);
      case (reg_sel)
         REG_ANALOG_MASK:  shadow_cfg.analog_mask  = value[MASK_W-1:0];
         REG_DIGITAL_MASK: shadow_cfg.digital_mask = value[MASK_W-1:0];
         REG_DEADBAND:     shadow_cfg.deadband     = value[VAL_W-1:0];
         default: ;
      endcase
   endfunction

   // Advances the shadow scanner by one request and returns the result it gives.
   function automatic rsp_type scan_step(input req_type item);
      rsp_type          r;
      logic [PTR_W-1:0] ch;
      logic [VAL_W-1:0] diff;
      logic [VAL_W-1:0] fresh;
      logic             store;
      ch    = scan_q;
      store = 1'b0;
      fresh = '0;
      diff  = '0;
      case (item.action)
         ACT_SAMPLE: begin
            if (int'(ch) < NCH) begin
               if (shadow_cfg.analog_mask[ch]) begin
                  diff = (chan_level[ch] > item.adc_value) ? chan_level[ch] - item.adc_value
                                                           : item.adc_value - chan_level[ch];
                  if (diff > shadow_cfg.deadband) begin
                     store = 1'b1;
                     fresh = item.adc_value;
                  end
               end else if (shadow_cfg.digital_mask[ch]) begin
                  store = 1'b1;
                  fresh = {{(VAL_W-1){1'b0}}, item.pin_level};
               end
               if (store) begin
                  if (chan_level[ch] != fresh) changed_q[ch] = 1'b1;
                  chan_level[ch] = fresh;
               end
            end
            scan_q = (int'(ch) + 1 >= NCH) ? '0 : ch + 1'b1;
         end
         ACT_CLEAR: changed_q = '0;
         default: ;
      endcase
      if (int'(item.read_index) < NCH) begin
         r.read_value = {{(RD_W-VAL_W){1'b0}}, chan_level[item.read_index]};
      end else begin
         r.read_value = RD_OUT_OF_RANGE;
      end
      r.changed_flags = changed_q;
      r.next_channel  = scan_q;
      return r;
   endfunction

   function automatic plan_row_type row_write(input logic [1:0] reg_sel, input int value);
      plan_row_type row;
      row          = '0;
      row.is_write = 1'b1;
      row.reg_sel  = reg_sel;
      row.wdata    = value;
      return row;
   endfunction

   function automatic plan_row_type row_beat(input logic [1:0] act, input int adc, input bit pin,
                                             input int idx);
      plan_row_type row;
      row                 = '0;
      row.item.action     = act;
      row.item.adc_value  = VAL_W'(adc);
      row.item.pin_level  = pin;
      row.item.read_index = 3'(idx);
      return row;
   endfunction

   function automatic plan_row_type row_known(input logic [1:0] act, input int adc, input bit pin,
                                              input int idx, input int rv, input int flags,
                                              input int nxt);
      plan_row_type row;
      row                      = row_beat(act, adc, pin, idx);
      row.typed                = 1'b1;
      row.golden.read_value    = RD_W'(rv);
      row.golden.changed_flags = MASK_W'(flags);
      row.golden.next_channel  = PTR_W'(nxt);
      return row;
   endfunction

   task automatic send_beat(input req_type item, input bit typed, input rsp_type golden);
      rsp_type predicted;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = scan_step(item);
      expected_scans.push_back(typed ? golden : predicted);
   endtask

   // Registers may only change once every outstanding result has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_scans.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] reg_sel, input logic [DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cfg_apply(reg_sel, value);
   endtask

   // Result side: random stalls, plus one long hold-off when asked for.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_scans.size() == 0) begin
            $error("result beat arrived with nothing outstanding");
            mismatches++;
         end else begin
            want = expected_scans.pop_front();
            if (rsp_data.read_value !== want.read_value) begin
               $error("read_value: expected %0h, got %0h",
                      want.read_value, rsp_data.read_value);
               mismatches++;
            end
            if (rsp_data.changed_flags !== want.changed_flags) begin
               $error("changed_flags: expected %0h, got %0h",
                      want.changed_flags, rsp_data.changed_flags);
               mismatches++;
            end
            if (rsp_data.next_channel !== want.next_channel) begin
               $error("next_channel: expected %0d, got %0d",
                      want.next_channel, rsp_data.next_channel);
               mismatches++;
            end
         end
      end
   end

   initial begin
      req_type          item;
      logic [MASK_W-1:0] amask;
      logic [MASK_W-1:0] dmask;
      logic [VAL_W-1:0]  dband;
      int               roll;
      int               base;
      int               span;
      int               near_val;

      shadow_cfg = '{analog_mask: '0, digital_mask: '0, deadband: DEADBAND_RST};
      foreach (chan_level[i]) chan_level[i] = '0;
      changed_q = '0;
      scan_q    = '0;

      // Straight after reset every channel is of neither kind.
      plan.push_back(row_known(ACT_QUERY,      0, 1'b0, 0, 0, 0, 0));
      plan.push_back(row_known(ACT_QUERY,   1023, 1'b1, 7, 16'hFFFF, 0, 0));
      plan.push_back(row_known(ACT_UNKNOWN,    0, 1'b0, 6, 16'hFFFF, 0, 0));
      plan.push_back(row_known(ACT_SAMPLE,  1023, 1'b1, 0, 0, 0, 1));
      plan.push_back(row_known(ACT_SAMPLE,   512, 1'b0, 1, 0, 0, 2));
      plan.push_back(row_known(ACT_SAMPLE,     1, 1'b1, 2, 0, 0, 3));
      plan.push_back(row_known(ACT_SAMPLE,  1023, 1'b1, 3, 0, 0, 4));
      plan.push_back(row_known(ACT_SAMPLE,     0, 1'b1, 4, 0, 0, 5));
      plan.push_back(row_known(ACT_SAMPLE,  1023, 1'b1, 5, 0, 0, 0));
      // Channel 0 is marked both analog and digital; analog must win.
      plan.push_back(row_write(REG_ANALOG_MASK,  6'b000111));
      plan.push_back(row_write(REG_DIGITAL_MASK, 6'b111101));
      plan.push_back(row_write(REG_DEADBAND,     4));
      plan.push_back(row_beat(ACT_SAMPLE,     4, 1'b1, 0));
      plan.push_back(row_beat(ACT_SAMPLE,     5, 1'b0, 1));
      plan.push_back(row_beat(ACT_SAMPLE,  1023, 1'b0, 2));
      plan.push_back(row_beat(ACT_SAMPLE,     0, 1'b1, 3));
      plan.push_back(row_beat(ACT_SAMPLE,  1023, 1'b0, 4));
      plan.push_back(row_beat(ACT_SAMPLE,     0, 1'b1, 5));
      plan.push_back(row_known(ACT_CLEAR,      0, 1'b0, 7, 16'hFFFF, 0, 0));
      plan.push_back(row_beat(ACT_QUERY,      0, 1'b0, 2));
      plan.push_back(row_write(REG_DEADBAND, 1023));
      plan.push_back(row_write(REG_UNUSED,   -1));
      plan.push_back(row_beat(ACT_SAMPLE,  1023, 1'b0, 0));
      plan.push_back(row_beat(ACT_SAMPLE,     0, 1'b1, 1));
      plan.push_back(row_write(REG_ANALOG_MASK,  6'b111111));
      plan.push_back(row_write(REG_DIGITAL_MASK, 0));
      plan.push_back(row_write(REG_DEADBAND,     0));
      plan.push_back(row_beat(ACT_SAMPLE,  1022, 1'b0, 2));
      plan.push_back(row_beat(ACT_SAMPLE,     0, 1'b0, 3));
      plan.push_back(row_beat(ACT_QUERY,      0, 1'b1, 6));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_write) begin
            wait_drained();
            csr_write(plan[i].reg_sel, plan[i].wdata);
         end else begin
            send_beat(plan[i].item, plan[i].typed, plan[i].golden);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               amask = '1;
               dmask = '0;
               dband = '0;
            end
            1: begin
               amask = '0;
               dmask = '1;
               dband = '1;
            end
            default: begin
               amask = MASK_W'($urandom_range(0, 63));
               dmask = MASK_W'($urandom_range(0, 63));
               dband = VAL_W'($urandom_range(0, 1) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, 1023));
            end
         endcase
         wait_drained();
         csr_write(REG_ANALOG_MASK,  DATA_W'(amask));
         csr_write(REG_DIGITAL_MASK, DATA_W'(dmask));
         csr_write(REG_DEADBAND,     DATA_W'(dband));

         // Phase 3 and the final phase run at full rate on both sides.
         idle_on = (phase != NUM_PHASES - 1) && (phase != 3);
         // Fill the result buffer so that the request side has to stall.
         if (phase == 2) hold_off_req = 1'b1;

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            roll = $urandom_range(0, 19);
            if (roll < 14)      item.action = ACT_SAMPLE;
            else if (roll < 16) item.action = ACT_CLEAR;
            else if (roll < 18) item.action = ACT_QUERY;
            else                item.action = ACT_UNKNOWN;
            // Half the samples land just either side of the deadband edge.
            if ($urandom_range(0, 1)) begin
               item.adc_value = VAL_W'($urandom_range(0, 1023));
            end else begin
               base     = int'(chan_level[scan_q]);
               span     = int'(shadow_cfg.deadband) + int'($urandom_range(0, 2)) - 1;
               if (span < 0) span = 0;
               near_val = $urandom_range(0, 1) ? base + span : base - span;
               if (near_val < 0)    near_val = 0;
               if (near_val > 1023) near_val = 1023;
               item.adc_value = VAL_W'(near_val);
            end
            item.pin_level  = 1'($urandom_range(0, 1));
            item.read_index = 3'($urandom_range(0, 7));
            send_beat(item, 1'b0, '0);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
